@@ sv/u2c_pkg.sv @@
// Shared types, constants and the CP-1252 mapping function for the UTF-8 to CP-1252
// path transcoder. No dependencies.
package u2c_pkg;

   // Longest path accepted, in input bytes
   localparam int MAX_PATH_BYTES = 256;
   // Byte counter saturates at MAX_PATH_BYTES + 1
   localparam int BCNT_W = $clog2(MAX_PATH_BYTES + 2);
   localparam int CCNT_W = 9;
   localparam int CP_W   = 21;

   localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
   localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
   localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;
   localparam logic [7:0]      CONT_MASK   = 8'hC0;
   localparam logic [7:0]      CONT_TAG    = 8'h80;
   localparam logic [7:0]      PAYLOAD6    = 8'h3F;
   localparam logic [7:0]      CTRL_LIMIT  = 8'h20;
   localparam logic [7:0]      CHAR_COLON  = 8'h3A;
   localparam logic [7:0]      CHAR_BSLASH = 8'h5C;

   // Path status, also the held error code
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_LONG = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // Code points behind CP-1252 bytes 0x80..0x9F, zero where the byte is unassigned
   localparam logic [15:0] CP_HIGH [32] = '{
      16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
      16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
   };

   // CP-1252 byte for a code point; zero when not representable (U+0000 too)
   function automatic logic [7:0] map_cp1252(input logic [CP_W-1:0] cp);
      logic [7:0] res;
      res = 8'h00;
      if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
         res = cp[7:0];
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (CP_HIGH[k] != 16'h0000 && {5'b0, CP_HIGH[k]} == cp) begin
               res = 8'h80 | 8'(k);
            end
         end
      end
      return res;
   endfunction

endpackage

@@ sv/u2c_ifs.sv @@
// Valid/ready channel interfaces for the transcoder: input bytes and result transactions.
// Depends on nothing.
interface u2c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last;

   modport source (output valid, output in_byte, output last, input ready);
   modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface u2c_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] char_byte;
   logic       done_res;
   logic [1:0] status;
   logic [8:0] out_length;

   modport source (output valid, output char_valid, output char_byte, output done_res,
                   output status, output out_length, input ready);
   modport sink   (input valid, input char_valid, input char_byte, input done_res,
                   input status, input out_length, output ready);
endinterface

@@ sv/utf8_to_cp1252_path_transcoder_top.sv @@
// Each accepted input byte yields its result transaction in the cycle after it is accepted.
// Throughput: one byte per cycle while the receiver takes results; decode, mapping and
// checks sit in front of a single result register, which also parts the two channels.
// Reset (synchronous, active high) clears the decoder state, counters, held error
// and the result valid flag. Depends on u2c_pkg and the channel interfaces in u2c_ifs.
module utf8_to_cp1252_path_transcoder_top (
   input logic         clock,
   input logic         reset,
   u2c_req_if.sink     req_chan,
   u2c_rsp_if.source   rsp_chan
);
   import u2c_pkg::*;

   // Decoder state
   logic [BCNT_W-1:0] byte_count_ff, byte_count_in;
   logic [1:0]        bytes_pending_ff, bytes_pending_in;
   logic [1:0]        seq_len_ff, seq_len_in;
   logic [CP_W-1:0]   partial_ff, partial_in;
   logic [CCNT_W-1:0] char_count_ff, char_count_in;
   status_type        err_ff, err_in;

   // Result register
   logic              rsp_valid_ff;
   logic              char_valid_ff, char_valid_in;
   logic [7:0]        char_byte_ff, char_byte_in;
   logic              done_ff;
   logic [1:0]        status_ff, status_in;
   logic [CCNT_W-1:0] out_length_ff, out_length_in;

   logic              req_fire;
   logic [7:0]        b;
   logic              is_last;
   logic              have_cp;
   logic [CP_W-1:0]   cp;
   logic [CP_W-1:0]   shifted;
   logic [CP_W-1:0]   min_val;
   logic [7:0]        mapped;
   logic [BCNT_W-1:0] bcount_step;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;
   assign is_last        = req_chan.last;

   // Decode one byte against the current state
   always_comb begin
      bcount_step      = byte_count_ff;
      err_in           = err_ff;
      bytes_pending_in = bytes_pending_ff;
      seq_len_in       = seq_len_ff;
      partial_in       = partial_ff;
      char_count_in    = char_count_ff;
      have_cp          = 1'b0;
      cp               = '0;
      char_valid_in    = 1'b0;
      char_byte_in     = 8'h00;
      shifted          = {partial_ff[CP_W-7:0], b[5:0]};
      mapped           = 8'h00;

      // Count bytes, saturating one past the limit
      if (byte_count_ff <= BCNT_W'(MAX_PATH_BYTES)) begin
         bcount_step = byte_count_ff + BCNT_W'(1);
      end
      if (bcount_step > BCNT_W'(MAX_PATH_BYTES)) begin
         err_in = ST_LONG;
      end

      // Minimum value per sequence length, to reject overlong forms
      case (seq_len_ff)
         2'd1:    min_val = MIN_2BYTE;
         2'd2:    min_val = MIN_3BYTE;
         default: min_val = MIN_4BYTE;
      endcase

      if (err_in == ST_OK) begin
         if (bytes_pending_ff == 2'd0) begin
            // Expect a lead byte
            if (b < 8'h80) begin
               cp      = {13'b0, b};
               have_cp = 1'b1;
            end else if (b < 8'hC0) begin
               err_in = ST_BAD;
            end else if (b < 8'hE0) begin
               bytes_pending_in = 2'd1;
               seq_len_in       = 2'd1;
               partial_in       = {16'b0, b[4:0]};
            end else if (b < 8'hF0) begin
               bytes_pending_in = 2'd2;
               seq_len_in       = 2'd2;
               partial_in       = {17'b0, b[3:0]};
            end else if (b < 8'hF8) begin
               bytes_pending_in = 2'd3;
               seq_len_in       = 2'd3;
               partial_in       = {18'b0, b[2:0]};
            end else begin
               err_in = ST_BAD;
            end
         end else if ((b & CONT_MASK) != CONT_TAG) begin
            err_in = ST_BAD;
         end else begin
            // Gather continuation bits, check on the final one
            partial_in       = shifted;
            bytes_pending_in = bytes_pending_ff - 2'd1;
            if (bytes_pending_ff == 2'd1) begin
               if (shifted < min_val || shifted > CP_MAX ||
                   (shifted >= SURR_LO && shifted <= SURR_HI)) begin
                  err_in = ST_BAD;
               end else begin
                  cp      = shifted;
                  have_cp = 1'b1;
               end
            end
         end

         // Map and screen a completed character
         if (have_cp) begin
            mapped = map_cp1252(cp);
            if (mapped < CTRL_LIMIT || mapped == CHAR_COLON || mapped == CHAR_BSLASH) begin
               err_in = ST_BAD;
            end else begin
               char_valid_in = 1'b1;
               char_byte_in  = mapped;
               char_count_in = char_count_ff + CCNT_W'(1);
            end
         end

         // Flag a sequence cut off by the last byte
         if (is_last && err_in == ST_OK && bytes_pending_in != 2'd0) begin
            err_in = ST_BAD;
         end
      end

      status_in     = is_last ? 2'(err_in) : 2'd0;
      out_length_in = (is_last && err_in == ST_OK) ? char_count_in : '0;
      byte_count_in = bcount_step;
   end

   // Advance decoder state; clear it after the last byte of a path
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         bytes_pending_ff <= 2'd0;
         seq_len_ff       <= 2'd0;
         partial_ff       <= '0;
         char_count_ff    <= '0;
         err_ff           <= ST_OK;
      end else if (req_fire) begin
         if (is_last) begin
            byte_count_ff    <= '0;
            bytes_pending_ff <= 2'd0;
            seq_len_ff       <= 2'd0;
            partial_ff       <= '0;
            char_count_ff    <= '0;
            err_ff           <= ST_OK;
         end else begin
            byte_count_ff    <= byte_count_in;
            bytes_pending_ff <= bytes_pending_in;
            seq_len_ff       <= seq_len_in;
            partial_ff       <= partial_in;
            char_count_ff    <= char_count_in;
            err_ff           <= err_in;
         end
      end
   end

   // Hold the result transaction until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_valid_ff <= char_valid_in;
         char_byte_ff  <= char_byte_in;
         done_ff       <= is_last;
         status_ff     <= status_in;
         out_length_ff <= out_length_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.char_valid = char_valid_ff;
   assign rsp_chan.char_byte  = char_byte_ff;
   assign rsp_chan.done_res   = done_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.out_length = out_length_ff;

`ifndef NO_ASSERTIONS
   // A path's last byte leaves the decoder idle
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_last |=> byte_count_ff == '0 && bytes_pending_ff == 2'd0 &&
                              char_count_ff == '0 && err_ff == ST_OK)
      else $error("decoder state not cleared after last byte");

   // Pending continuations never exceed the sequence length
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_pending_ff <= seq_len_ff)
      else $error("pending count exceeds sequence length");

   // An error stays held until the last byte
   a_error_held: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_last && err_ff != ST_OK |=> err_ff != ST_OK)
      else $error("held error dropped before end of path");

   // A stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(char_byte_ff) &&
                                          $stable(status_ff) && $stable(out_length_ff))
      else $error("stalled result changed");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for utf8_to_cp1252_path_transcoder_top: random and directed
// UTF-8 paths, a transaction-level transcode predictor and an in-order result checker.
// Depends on u2c_pkg, the channel interfaces in u2c_ifs and the transcoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import u2c_pkg::*;

   // One result transaction, as seen on the result channel
   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_byte;
      logic       done_res;
      status_type status;
      logic [8:0] out_length;
   } xcode_result_type;

   // Kinds of damage injected into otherwise well-formed paths
   typedef enum int {
      FLT_CTRL, FLT_COLON, FLT_BSLASH, FLT_STRAY, FLT_LONG_LEAD, FLT_BAD_CONT,
      FLT_OVERLONG, FLT_SURROGATE, FLT_ABOVE_MAX, FLT_UNMAPPED, FLT_CUT_OFF,
      FLT_NOISE, FLT_COUNT
   } fault_kind_type;

   // Receiver stall patterns
   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_type;

   // Transcode predictor plus in-order result checker
   class transcode_scoreboard;
      int               bytes_in_path;
      int               conts_left;
      int               conts_total;
      logic [20:0]      partial_cp;
      int               chars_in_path;
      status_type       path_error;
      logic [7:0]       high_byte_of [int];
      xcode_result_type results_due [$];
      int               mismatches;
      int               results_checked;
      int               chars_checked;
      int               bytes_noted;
      int               paths_ok, paths_long, paths_bad;

      function new();
         foreach (CP_HIGH[k]) begin
            if (CP_HIGH[k] != 16'h0000) high_byte_of[int'(CP_HIGH[k])] = 8'h80 + 8'(k);
         end
         clear_path();
      endfunction

      function void clear_path();
         bytes_in_path = 0;
         conts_left    = 0;
         conts_total   = 0;
         partial_cp    = '0;
         chars_in_path = 0;
         path_error    = ST_OK;
      endfunction

      // CP-1252 byte for a code point, zero when it has none
      function logic [7:0] cp1252_of(logic [20:0] cp);
         if (cp <= 21'h7F || (cp >= 21'hA0 && cp <= 21'hFF)) return cp[7:0];
         if (high_byte_of.exists(int'(cp))) return high_byte_of[int'(cp)];
         return 8'h00;
      endfunction

      // Advance the path state by one accepted byte and queue its result
      function void note_byte(logic [7:0] b, logic is_last);
         xcode_result_type r;
         logic [20:0]      cp;
         logic [20:0]      floor_cp;
         logic [7:0]       ob;
         bit               have_cp;
         r = '0;
         cp = '0;
         have_cp = 0;
         bytes_noted++;
         if (bytes_in_path <= MAX_PATH_BYTES) bytes_in_path++;
         if (bytes_in_path > MAX_PATH_BYTES) path_error = ST_LONG;
         if (path_error == ST_OK) begin
            if (conts_left == 0) begin
               if (b < 8'h80) begin
                  cp = {13'b0, b};
                  have_cp = 1;
               end else if (b < 8'hC0) begin
                  path_error = ST_BAD;
               end else if (b < 8'hE0) begin
                  conts_left = 1; conts_total = 1; partial_cp = {16'b0, b[4:0]};
               end else if (b < 8'hF0) begin
                  conts_left = 2; conts_total = 2; partial_cp = {17'b0, b[3:0]};
               end else if (b < 8'hF8) begin
                  conts_left = 3; conts_total = 3; partial_cp = {18'b0, b[2:0]};
               end else begin
                  path_error = ST_BAD;
               end
            end else if ((b & CONT_MASK) != CONT_TAG) begin
               path_error = ST_BAD;
            end else begin
               partial_cp = {partial_cp[14:0], b[5:0]};
               conts_left--;
               if (conts_left == 0) begin
                  floor_cp = (conts_total == 1) ? MIN_2BYTE :
                             (conts_total == 2) ? MIN_3BYTE : MIN_4BYTE;
                  if (partial_cp < floor_cp || partial_cp > CP_MAX ||
                      (partial_cp >= SURR_LO && partial_cp <= SURR_HI)) begin
                     path_error = ST_BAD;
                  end else begin
                     cp = partial_cp;
                     have_cp = 1;
                  end
               end
            end
            // Map and screen the completed character
            if (have_cp) begin
               ob = cp1252_of(cp);
               if (ob == 8'h00 || ob < CTRL_LIMIT || ob == CHAR_COLON || ob == CHAR_BSLASH) begin
                  path_error = ST_BAD;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_byte  = ob;
                  chars_in_path++;
               end
            end
            if (is_last && path_error == ST_OK && conts_left != 0) path_error = ST_BAD;
         end
         r.done_res = is_last;
         if (is_last) begin
            r.status = path_error;
            if (path_error == ST_OK) r.out_length = 9'(chars_in_path);
            case (path_error)
               ST_OK:   paths_ok++;
               ST_LONG: paths_long++;
               default: paths_bad++;
            endcase
            clear_path();
         end
         results_due.push_back(r);
      endfunction

      function string show(xcode_result_type r);
         return $sformatf("char_valid=%0b char_byte=%02h done_res=%0b status=%0d out_length=%0d",
                          r.char_valid, r.char_byte, r.done_res, r.status, r.out_length);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(xcode_result_type got);
         xcode_result_type want;
         string            bad_fields;
         if (results_due.size() == 0) begin
            report({"result with nothing expected: ", show(got)});
            return;
         end
         want = results_due.pop_front();
         results_checked++;
         if (want.char_valid) chars_checked++;
         bad_fields = "";
         if (got.char_valid !== want.char_valid) bad_fields = {bad_fields, " char_valid"};
         if (got.char_byte  !== want.char_byte)  bad_fields = {bad_fields, " char_byte"};
         if (got.done_res   !== want.done_res)   bad_fields = {bad_fields, " done_res"};
         if (got.status     !== want.status)     bad_fields = {bad_fields, " status"};
         if (got.out_length !== want.out_length) bad_fields = {bad_fields, " out_length"};
         if (bad_fields != "") begin
            report($sformatf("result %0d differs in%s\n   expected %s\n   actual   %s",
                             results_checked, bad_fields, show(want), show(got)));
         end
      endfunction

      function int outstanding();
         return results_due.size();
      endfunction

      // Count every expectation still waiting as a failure
      function void flush_missing();
         while (results_due.size() > 0) begin
            report({"expected result never arrived: ", show(results_due.pop_front())});
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   u2c_req_if req_chan ();
   u2c_rsp_if rsp_chan ();

   utf8_to_cp1252_path_transcoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   transcode_scoreboard sb = new();

   logic [7:0]       path_bytes [$];
   int               burst_left = 0;
   int               random_bytes_sent = 0;
   rx_pattern_type   rx_mode = RX_OPEN;
   int               rx_left = 0;
   int               rx_tick = 0;
   xcode_result_type rsp_seen;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Known values on every input from time zero
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.last    = 1'b0;
      rsp_chan.ready   = 1'b0;
   end

   // Receiver: switch between stall patterns, holding each for a random stretch
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(30, 150);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:  rsp_chan.ready <= 1'b1;
         RX_LIGHT: rsp_chan.ready <= ($urandom_range(0, 9) < 7);
         RX_HEAVY: rsp_chan.ready <= ($urandom_range(0, 9) < 3);
         default:  rsp_chan.ready <= (rx_tick % 4 == 0);
      endcase
   end

   // Monitor: check results first, then note accepted bytes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen.char_valid = rsp_chan.char_valid;
            rsp_seen.char_byte  = rsp_chan.char_byte;
            rsp_seen.done_res   = rsp_chan.done_res;
            rsp_seen.status     = status_type'(rsp_chan.status);
            rsp_seen.out_length = rsp_chan.out_length;
            sb.check_result(rsp_seen);
         end
         if (req_chan.valid && req_chan.ready) sb.note_byte(req_chan.in_byte, req_chan.last);
      end
   end

   // Hard stop
   initial begin
      #3_000_000;
      $display("Timeout: the run did not finish in time");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one byte, in bursts with random gaps, and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 120)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.last    <= is_last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_path();
      foreach (path_bytes[i]) send_byte(path_bytes[i], i == path_bytes.size() - 1);
   endtask

   // Hold the sender until every expected result has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_printable();
      logic [7:0] b;
      do b = 8'($urandom_range(8'h20, 8'h7E));
      while (b == CHAR_COLON || b == CHAR_BSLASH);
      return b;
   endfunction

   // Encode a code point in n bytes; n of zero picks the shortest form
   function automatic void push_utf8(logic [20:0] cp, int n);
      if (n == 0) n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      case (n)
         1: path_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            path_bytes.push_back({3'b110, cp[10:6]});
            path_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            path_bytes.push_back({4'b1110, cp[15:12]});
            path_bytes.push_back({2'b10, cp[11:6]});
            path_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            path_bytes.push_back({5'b11110, cp[20:18]});
            path_bytes.push_back({2'b10, cp[17:12]});
            path_bytes.push_back({2'b10, cp[11:6]});
            path_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Representable character: plain ASCII, Latin-1 upper half or a remapped symbol
   function automatic void push_good_char();
      logic [20:0] cp;
      int          pick;
      int          k;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         cp = {13'b0, random_printable()};
      end else if (pick < 8) begin
         cp = 21'($urandom_range(8'hA0, 8'hFF));
      end else begin
         do k = $urandom_range(0, 31); while (CP_HIGH[k] == 16'h0000);
         cp = {5'b0, CP_HIGH[k]};
      end
      push_utf8(cp, 0);
   endfunction

   function automatic void push_fault(fault_kind_type f);
      logic [7:0]  b;
      logic [20:0] cp;
      int          n;
      case (f)
         FLT_CTRL:      path_bytes.push_back(8'($urandom_range(0, 31)));
         FLT_COLON:     path_bytes.push_back(CHAR_COLON);
         FLT_BSLASH:    path_bytes.push_back(CHAR_BSLASH);
         FLT_STRAY:     path_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
         FLT_LONG_LEAD: path_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         FLT_BAD_CONT: begin
            b = 8'($urandom_range(8'hC2, 8'hF4));
            path_bytes.push_back(b);
            if (b >= 8'hE0 && $urandom_range(0, 1)) path_bytes.push_back(8'hA0);
            do b = 8'($urandom_range(0, 255)); while ((b & CONT_MASK) == CONT_TAG);
            path_bytes.push_back(b);
         end
         FLT_OVERLONG: begin
            n = $urandom_range(2, 4);
            cp = (n == 2) ? 21'($urandom_range(0, 21'h7F)) :
                 (n == 3) ? 21'($urandom_range(0, 21'h7FF)) : 21'($urandom_range(0, 21'hFFFF));
            push_utf8(cp, n);
         end
         FLT_SURROGATE: push_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
         FLT_ABOVE_MAX: push_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
         FLT_UNMAPPED: begin
            case ($urandom_range(0, 2))
               0:       cp = 21'($urandom_range(21'h80, 21'h9F));
               1:       cp = 21'($urandom_range(21'h100, 21'hFFFF));
               default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            endcase
            push_utf8(cp, 0);
         end
         FLT_CUT_OFF: begin
            // Full multi-byte sequence with its tail chopped off
            n = $urandom_range(2, 4);
            cp = (n == 2) ? 21'($urandom_range(21'h80, 21'h7FF)) :
                 (n == 3) ? 21'($urandom_range(21'h800, 21'hFFFF)) :
                            21'($urandom_range(21'h10000, 21'h10FFFF));
            push_utf8(cp, n);
            repeat ($urandom_range(1, n - 1)) void'(path_bytes.pop_back());
         end
         default: repeat ($urandom_range(1, 6)) path_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // Mostly clean paths; a quarter carry one fault somewhere
   function automatic void build_random_path();
      int             n_chars;
      int             fault_at;
      bit             broken;
      fault_kind_type f;
      path_bytes.delete();
      n_chars  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      broken   = ($urandom_range(0, 3) == 0);
      f        = fault_kind_type'($urandom_range(0, FLT_COUNT - 1));
      fault_at = $urandom_range(0, n_chars - 1);
      for (int i = 0; i < n_chars; i++) begin
         if (broken && i == fault_at && f != FLT_CUT_OFF) push_fault(f);
         push_good_char();
      end
      if (broken && f == FLT_CUT_OFF) push_fault(f);
   endfunction

   // Stimulus
   initial begin
      bit drained_midway;
      drained_midway = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes and most rejection rules (not bad continuations or unmapped code points)
      path_bytes = '{8'h41};                                         send_path();
      path_bytes = '{8'h7F, 8'hE2, 8'h82, 8'hAC, 8'hC3, 8'hBF, 8'h20}; send_path();
      path_bytes = '{8'h00};                                         send_path();
      path_bytes = '{8'h80};                                         send_path();
      path_bytes = '{8'hFF};                                         send_path();
      path_bytes = '{8'hC0, 8'h80};                                  send_path();
      path_bytes = '{8'hED, 8'hA0, 8'h80};                           send_path();
      path_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};                    send_path();
      path_bytes = '{CHAR_COLON};                                    send_path();
      path_bytes = '{CHAR_BSLASH};                                   send_path();
      path_bytes = '{8'hC3};                                         send_path();
      path_bytes = '{8'h1F};                                         send_path();
      wait_for_drain();

      // Length boundary: exactly the maximum, then one over with an earlier error
      path_bytes.delete();
      repeat (MAX_PATH_BYTES) path_bytes.push_back(random_printable());
      send_path();
      path_bytes.delete();
      repeat (MAX_PATH_BYTES + 1) path_bytes.push_back(random_printable());
      path_bytes[2] = 8'hFF;
      send_path();
      wait_for_drain();

      // Random paths, sized so the whole run stays near 700 bytes
      while (random_bytes_sent < 180) begin
         build_random_path();
         send_path();
         random_bytes_sent += path_bytes.size();
         if (!drained_midway && random_bytes_sent >= 90) begin
            wait_for_drain();
            drained_midway = 1;
         end
      end

      // Let the last results come home, then allow for the pipeline latency
      wait_for_drain();
      repeat (8) @(posedge clock);
      sb.flush_missing();

      $display("Covered %0d input bytes in %0d paths: %0d ok, %0d too long, %0d rejected.",
               sb.bytes_noted, sb.paths_ok + sb.paths_long + sb.paths_bad,
               sb.paths_ok, sb.paths_long, sb.paths_bad);
      $display("Checked %0d result transactions carrying %0d characters, %0d mismatches.",
               sb.results_checked, sb.chars_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ utf8_to_cp1252_path_transcoder_top.f @@
sv/u2c_pkg.sv
sv/u2c_ifs.sv
sv/utf8_to_cp1252_path_transcoder_top.sv
tb/tb_top.sv
